### design/bounded_deque_with_remove_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque core
// Clocked implication checks with a disable-on-reset guard.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_REMOVE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_CORE_MACROS_SVH

// Same-cycle implication: when a holds, c holds on the same edge.
`define BDQ_ASSERT_NOW(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication: when a holds, c holds on the following edge.
`define BDQ_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

### design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Command and status codes and fixed field widths of the deque core.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CMD_W      = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int OUT_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

### design/bdq_store.sv
// ----------------------------------------------------------------------------
// bdq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_store
  import bdq_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  value_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output value_t            rdata
);

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bounded_deque_with_remove_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_remove_core
// Bounded double-ended queue of 32-bit values with remove by value.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats arrive on the s_ group: s_tuser carries the command (push
//   front, push back, pop front, pop back, remove value) and s_tdata the
//   value. Every request yields exactly one result beat on the m_ group:
//   m_tuser carries the status and m_tdata the entry count afterwards.
//   Pushes, pops and unknown commands finish in the accept cycle; the result
//   is registered and shows in the cycle after. Remove walks the circular
//   entry memory through its single read port: front entry, back entry,
//   then inner entries one per cycle, then moves each later entry forward
//   one place to close the gap. s_tready is high only while the sequencer
//   is idle and the result register is empty or being drained, so one
//   request is in flight. A stalled receiver holds the result in its
//   register and holds off new requests. Reset empties the deque; the entry
//   memory is not cleared, as only live entries are ever compared or moved.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_remove_core_macros.svh"

module bounded_deque_with_remove_core
  import bdq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VALUE_W-1:0]    s_tdata,   // [31:0] item_value
  input  logic [CMD_W-1:0]      s_tuser,   // [2:0] cmd
  // result channel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [4:0] entry_count, [7:5] zero
  output logic [STATUS_W-1:0]   m_tuser    // [1:0] status
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 2;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CMP_FRONT = 3'd1;
  localparam logic [2:0] S_CMP_BACK  = 3'd2;
  localparam logic [2:0] S_SCAN      = 3'd3;
  localparam logic [2:0] S_SHIFT     = 3'd4;

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = (s >= SUM_W'(CAPACITY)) ? s - SUM_W'(CAPACITY) : s;
    slot_wrap = t[IDX_W-1:0];
  endfunction

  logic [2:0]          state, state_next;
  logic [IDX_W-1:0]    front, front_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    slot, slot_next;     // slot of the scan position
  logic [CNT_W-1:0]    pos, pos_next;       // scan position from the front
  value_t              value, value_next;   // value being searched
  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic [COUNT_W-1:0]  out_count, out_count_next;

  logic                finish;
  logic [STATUS_W-1:0] fin_status;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  logic [IDX_W-1:0] front_dec, front_inc, back_slot, tail_slot, slot_inc1, slot_inc2;
  logic             more_inner;
  logic             s_accept;

  // check terms
  logic             busy;
  logic             scan_active;
  logic             scan_in_range;

  // memory port
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  value_t           mem_wdata, mem_rdata;

  bdq_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign s_tready = (state == S_IDLE) && (!out_valid || m_tready);
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(OUT_DATA_W - COUNT_W){1'b0}}, out_count};

  // slot arithmetic: front - 1, front + 1, back and tail slots, scan steps
  assign front_dec = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_inc = slot_inc(front);
  assign back_slot = slot_wrap(SUM_W'(front) + SUM_W'(count) - SUM_W'(1));
  assign tail_slot = slot_wrap(SUM_W'(front) + SUM_W'(count));
  assign slot_inc1 = slot_inc(slot);
  assign slot_inc2 = slot_inc(slot_inc1);
  // another inner entry follows the current position (pos + 2 < count)
  assign more_inner = ((CNT_W + 1)'(pos) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(count);

  always_comb begin
    state_next      = state;
    front_next      = front;
    count_next      = count;
    slot_next       = slot;
    pos_next        = pos;
    value_next      = value;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_count_next  = out_count;
    finish          = 1'b0;
    fin_status      = ST_OK;
    mem_we          = 1'b0;
    mem_waddr       = slot;
    mem_wdata       = mem_rdata;
    mem_re          = 1'b0;
    mem_raddr       = slot;

    // drop the result once the receiver takes it
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (s_accept) begin
          value_next = s_tdata;
          case (s_tuser)
            CMD_PUSH_FRONT: begin
              finish = 1'b1;
              if (count == FULL_CNT) begin
                fin_status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = front_dec;
                mem_wdata  = s_tdata;
                front_next = front_dec;
                count_next = count + 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              finish = 1'b1;
              if (count == FULL_CNT) begin
                fin_status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = tail_slot;
                mem_wdata  = s_tdata;
                count_next = count + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              finish = 1'b1;
              if (count == '0) begin
                fin_status = ST_EMPTY;
              end else begin
                front_next = front_inc;
                count_next = count - 1'b1;
              end
            end
            CMD_POP_BACK: begin
              finish = 1'b1;
              if (count == '0) begin
                fin_status = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (count == '0) begin
                finish     = 1'b1;
                fin_status = ST_NOT_FOUND;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = front;
                state_next = S_CMP_FRONT;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_CMP_FRONT: begin
        if (mem_rdata == value) begin
          front_next = front_inc;
          count_next = count - 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = back_slot;
          state_next = S_CMP_BACK;
        end
      end

      S_CMP_BACK: begin
        if (mem_rdata == value) begin
          count_next = count - 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else if ((CNT_W + 1)'(count) < (CNT_W + 1)'(3)) begin
          // no inner entries to search
          finish     = 1'b1;
          fin_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = front_inc;
          slot_next  = front_inc;
          pos_next   = CNT_W'(1);
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        if (mem_rdata == value) begin
          // fetch the next entry to move it into the freed slot
          mem_re     = 1'b1;
          mem_raddr  = slot_inc1;
          state_next = S_SHIFT;
        end else if (more_inner) begin
          mem_re     = 1'b1;
          mem_raddr  = slot_inc1;
          slot_next  = slot_inc1;
          pos_next   = pos + 1'b1;
        end else begin
          finish     = 1'b1;
          fin_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end
      end

      S_SHIFT: begin
        // move entry pos + 1 down to pos, prefetch pos + 2
        mem_we    = 1'b1;
        mem_waddr = slot;
        mem_wdata = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = slot_inc2;
        slot_next = slot_inc1;
        pos_next  = pos + 1'b1;
        if (!more_inner) begin
          count_next = count - 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    count_ext = {{COUNT_W{1'b0}}, count_next};
    if (finish) begin
      out_valid_next  = 1'b1;
      out_status_next = fin_status;
      out_count_next  = count_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    slot       <= slot_next;
    pos        <= pos_next;
    value      <= value_next;
    out_status <= out_status_next;
    out_count  <= out_count_next;
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  assign busy          = m_tvalid || (state != S_IDLE);
  assign scan_active   = (state == S_SCAN) || (state == S_SHIFT);
  assign scan_in_range = ((CNT_W + 1)'(pos) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(count);

  `BDQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= FULL_CNT, "count above capacity")
  `BDQ_ASSERT_NOW(a_front_bound, clk, rst, 1'b1, front <= LAST_SLOT, "front slot out of range")
  `BDQ_ASSERT_NEXT(a_accept_busy, clk, rst, s_accept, busy, "request lost")
  `BDQ_ASSERT_NOW(a_scan_range, clk, rst, scan_active, scan_in_range, "scan past back entry")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bounded deque core against a cycle-free model of the deque.
// Every result beat is checked against a predicted status and entry count.
// Stimulus is a short directed run through the corner cases, then random
// phases that fill, drain and churn the deque. Valid and ready are
// throttled at random.
// ----------------------------------------------------------------------------
module testbench;
  import bdq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_CAP     = 40;

  // Deque contents as the model sees them: circular store, front slot, size.
  typedef struct packed {
    logic [DEPTH-1:0][VALUE_W-1:0] vals;
    logic [3:0]                    head;
    logic [COUNT_W-1:0]            count;
  } deque_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  typedef struct {
    logic [CMD_W-1:0] op;
    value_t           value;
    bit               hold_off;  // present only once every result is back
  } request_t;

  typedef enum {FILL_UP, WIND_DOWN, CHURN} phase_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata = '0;   // [31:0] item_value
  logic [CMD_W-1:0]      s_tuser = '0;   // [2:0] cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [4:0] entry_count, [7:5] zero
  logic [STATUS_W-1:0]   m_tuser;        // [1:0] status

  request_t pending_requests[$];
  outcome_t expected_results[$];
  deque_t   plan_state;    // deque as the stimulus generator expects it
  deque_t   model_state;   // deque as predicted from accepted beats
  request_t drive_req;

  bit s_took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_hold = 0;
  int cycle_count = 0;
  int error_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  bounded_deque_with_remove_core #(
    .CAPACITY(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to a deque and return the status and new size.
  // Remove looks at the front, then the back, then the inner entries from
  // front to back, and closes the gap by moving later entries forward.
  function automatic outcome_t deque_step(inout deque_t dq,
                                          input logic [CMD_W-1:0] op,
                                          input value_t val);
    outcome_t res;
    logic [3:0] slot;
    logic [3:0] next_slot;
    int hit;
    int k;
    res.status = ST_OK;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (dq.count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (op == CMD_PUSH_FRONT) begin
            dq.head = dq.head - 4'd1;
            slot = dq.head;
          end else begin
            slot = dq.head + dq.count[3:0];
          end
          dq.vals[slot] = val;
          dq.count = dq.count + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (dq.count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == CMD_POP_FRONT) dq.head = dq.head + 4'd1;
          dq.count = dq.count - 1'b1;
        end
      end
      CMD_REMOVE: begin
        slot = dq.head + dq.count[3:0] - 4'd1;
        if (dq.count == 0) begin
          res.status = ST_NOT_FOUND;
        end else if (dq.vals[dq.head] == val) begin
          dq.head = dq.head + 4'd1;
          dq.count = dq.count - 1'b1;
        end else if (dq.vals[slot] == val) begin
          dq.count = dq.count - 1'b1;
        end else begin
          hit = -1;
          for (k = 1; k + 1 < int'(dq.count); k++) begin
            slot = dq.head + 4'(k);
            if (hit < 0 && dq.vals[slot] == val) hit = k;
          end
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            for (k = hit; k + 1 < int'(dq.count); k++) begin
              slot = dq.head + 4'(k);
              next_slot = dq.head + 4'(k + 1);
              dq.vals[slot] = dq.vals[next_slot];
            end
            dq.count = dq.count - 1'b1;
          end
        end
      end
      default: ;  // unknown command: no change, status ok
    endcase
    res.count = dq.count;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < PRINT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  // Queue one request and track the deque as the block should see it.
  task automatic queue_request(input logic [CMD_W-1:0] op, input value_t val,
                               input bit hold_off);
    request_t req;
    outcome_t ignored;
    req.op = op;
    req.value = val;
    req.hold_off = hold_off;
    pending_requests.push_back(req);
    ignored = deque_step(plan_state, op, val);
  endtask

  // Often values from a small pool or corner values, so that duplicates and hits are common.
  function automatic value_t pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return value_t'($urandom_range(0, 7)) - value_t'(3);
    if (roll < 45) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: update at the falling edge. A beat stays up until the
  // rising edge that takes it; the next one goes up right behind it unless a
  // gap between bursts is due or the head request waits for a full drain.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_took || !s_tvalid) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].hold_off && expected_results.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        drive_req = pending_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= drive_req.value;
        s_tuser <= drive_req.op;
        if (burst_left <= 1) begin
          // close the burst; about four in ten bursts run straight on
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: the stall style rotates between always ready, short
  // random stalls and long stalls that back up the block.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ((cycle_count / 600) % 3)
        0: begin
          m_tready <= 1'b1;
          ready_hold <= 0;
        end
        1: begin
          m_tready <= $urandom_range(0, 1);
          ready_hold <= $urandom_range(0, 2);
        end
        default: begin
          m_tready <= ($urandom_range(0, 3) == 0);
          ready_hold <= $urandom_range(0, 29);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check a result beat
  // against the oldest prediction, then predict for a request beat taken on
  // the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      s_took <= 1'b0;
      model_state <= '0;
    end else begin
      s_took <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        checked_count++;
        status_tally[m_tuser]++;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no request waiting", m_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          got.status = m_tuser;
          got.count = m_tdata[COUNT_W-1:0];
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.count != want.count)
            report_mismatch("entry_count", got.count, want.count);
          if (m_tdata[OUT_DATA_W-1:COUNT_W] != '0)
            report_mismatch("tdata padding", m_tdata[OUT_DATA_W-1:COUNT_W], 0);
        end
      end
      if (s_tvalid && s_tready) begin
        accepted_count++;
        expected_results.push_back(deque_step(model_state, s_tuser, s_tdata));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    phase_kind_t kind;
    int random_items;
    int phase_len;
    int roll;
    int pos;
    int i;
    bit first_phase;
    bit hold_phase;
    logic [CMD_W-1:0] op;
    value_t val;
    logic [3:0] slot;

    plan_state = '0;
    random_items = 0;
    first_phase = 1'b1;

    // Empty deque: both pops report empty, remove reports not found.
    queue_request(CMD_POP_FRONT, 32'h0, 1'b0);
    queue_request(CMD_POP_BACK, 32'hffff_ffff, 1'b0);
    queue_request(CMD_REMOVE, 32'h0, 1'b0);
    // Codes above remove change nothing.
    queue_request(3'd5, 32'h1234_5678, 1'b0);
    queue_request(3'd6, 32'h8000_0000, 1'b0);
    queue_request(3'd7, 32'h7fff_ffff, 1'b0);
    // Build 5, -1, min, max, 0, 5, 9 from both ends.
    queue_request(CMD_PUSH_FRONT, 32'h8000_0000, 1'b0);
    queue_request(CMD_PUSH_BACK, 32'h7fff_ffff, 1'b0);
    queue_request(CMD_PUSH_FRONT, 32'hffff_ffff, 1'b0);
    queue_request(CMD_PUSH_BACK, 32'h0, 1'b0);
    queue_request(CMD_PUSH_FRONT, 32'd5, 1'b0);
    queue_request(CMD_PUSH_BACK, 32'd5, 1'b0);
    queue_request(CMD_PUSH_BACK, 32'd9, 1'b0);
    // 5 sits at the front and next to the back: the front copy goes. Then a
    // back hit, an inner hit with the gap closed, and a miss.
    queue_request(CMD_REMOVE, 32'd5, 1'b0);
    queue_request(CMD_REMOVE, 32'd9, 1'b0);
    queue_request(CMD_REMOVE, 32'h7fff_ffff, 1'b0);
    queue_request(CMD_REMOVE, 32'd77, 1'b0);
    queue_request(CMD_POP_FRONT, 32'h0, 1'b0);
    queue_request(CMD_POP_BACK, 32'h0, 1'b0);

    // Random phases. The first one fills the deque so pushes hit full early;
    // some phases start only after every result is back.
    while (random_items < RANDOM_ITEMS) begin
      kind = first_phase ? FILL_UP : phase_kind_t'($urandom_range(0, 2));
      phase_len = first_phase ? 60 : $urandom_range(20, 90);
      hold_phase = first_phase || ($urandom_range(0, 3) == 0);
      first_phase = 1'b0;
      for (i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          FILL_UP:   roll = (roll < 70) ? 0 : (roll < 80) ? 1 : (roll < 98) ? 2 : 3;
          WIND_DOWN: roll = (roll < 20) ? 0 : (roll < 75) ? 1 : (roll < 98) ? 2 : 3;
          default:   roll = (roll < 38) ? 0 : (roll < 58) ? 1 : (roll < 98) ? 2 : 3;
        endcase
        val = pick_value();
        case (roll)
          0: op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
          1: op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
          2: begin
            op = CMD_REMOVE;
            // mostly remove a live entry so hits land at every position
            if (plan_state.count != 0 && $urandom_range(0, 9) < 8) begin
              pos = $urandom_range(0, int'(plan_state.count) - 1);
              slot = plan_state.head + 4'(pos);
              val = plan_state.vals[slot];
            end
          end
          default: op = CMD_W'($urandom_range(5, 7));
        endcase
        queue_request(op, val, hold_phase && i == 0);
        random_items++;
      end
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Wait for the last request to go out and its result to come back.
    while (!(pending_requests.size() == 0 && !s_tvalid && expected_results.size() == 0)
           && cycle_count < LIMIT_CYCLES)
      @(posedge clk);
    if (cycle_count < LIMIT_CYCLES) repeat (SETTLE_CYCLES) @(posedge clk);

    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("status: fail");
    end else begin
      if (expected_results.size() != 0)
        report_mismatch("requests left without a result", expected_results.size(), 0);
      $display("ran %0d requests in %0d cycles; %0d results checked, %0d mismatches",
               accepted_count, cycle_count, checked_count, error_count);
      $display("results by status: ok %0d, empty %0d, not found %0d, full %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
      if (error_count == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/bdq_pkg.sv
design/bdq_store.sv
design/bounded_deque_with_remove_core.sv
sim/testbench.sv
